// ----- design/swpc_pkg.sv -----
// Shared types and constants for the sync word payload capture block.
package swpc_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_PATTERN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_LEN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAY_LEN      = 2'd2;

    localparam int CFG_DATA_W = 64;
    localparam int LEN_W      = 7;
    localparam int PAY_W      = 64;
    localparam int MAN_N      = 32;
    localparam int PWM_DATA_N = 21;
    localparam int PWM_N      = 22;

    // Symbol codes, first received bit in the MSB
    localparam logic [1:0] MAN_ONE  = 2'b10;
    localparam logic [1:0] MAN_ZERO = 2'b01;
    localparam logic [2:0] PWM_ONE  = 3'b100;
    localparam logic [2:0] PWM_ZERO = 3'b110;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 184;

    // Shift controls shared by every cell of the row
    typedef struct packed {
        logic hist_shift;
        logic cap_shift;
    } t_cell_ctrl;

    // Result word, last member in the lowest bits
    typedef struct packed {
        logic [1:0]            spare;
        logic [4:0]            pwm_count;
        logic [PWM_N-1:0]      pwm_bad;
        logic [PWM_DATA_N-1:0] pwm_data;
        logic [5:0]            man_count;
        logic [MAN_N-1:0]      man_bad;
        logic [MAN_N-1:0]      man_data;
        logic [PAY_W-1:0]      payload;
    } t_result;

endpackage

// ----- design/swpc_cell.sv -----
// One bit position of the history and capture shift chains, with its pattern compare.
module swpc_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  swpc_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_hist_in,
    input  logic                i_cap_in,
    input  logic                i_pat,
    input  logic                i_care,
    output logic                o_hist,
    output logic                o_cap,
    output logic                o_hit
);
    import swpc_pkg::*;

    logic r_hist;
    logic r_cap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= 1'b0;
            r_cap  <= 1'b0;
        end else begin
            if (i_ctrl.hist_shift) begin
                r_hist <= i_hist_in;
            end
            if (i_ctrl.cap_shift) begin
                r_cap <= i_cap_in;
            end
        end
    end

    assign o_hist = r_hist;
    assign o_cap  = r_cap;
    // positions above the sync length always agree
    assign o_hit  = !i_care || (r_hist == i_pat);

endmodule

// ----- design/swpc_decode.sv -----
// Manchester and PWM decode of a captured payload into one result word.
module swpc_decode (
    input  logic [swpc_pkg::PAY_W-1:0] i_payload,
    input  logic [swpc_pkg::LEN_W-1:0] i_dlen,
    output swpc_pkg::t_result          o_result
);
    import swpc_pkg::*;

    logic [PAY_W-1:0]   w_aligned;
    logic [PAY_W+1:0]   w_ext;
    logic [5:0]         w_lshift;
    logic [LEN_W+7:0]   w_pwm_prod;
    logic [1:0]         w_pair;
    logic [2:0]         w_trip;
    logic               w_whole;

    // first received bit moves to the MSB; two zero bits pad the last triple
    assign w_lshift  = 6'(7'd64 - i_dlen);
    assign w_aligned = i_payload << w_lshift;
    assign w_ext     = {w_aligned, 2'b00};
    // ceil(dlen/3) as (dlen+2)*171 >> 9, exact for this range
    assign w_pwm_prod = (15'(i_dlen) + 15'd2) * 15'd171;

    always_comb begin
        o_result           = '0;
        o_result.payload   = i_payload;
        o_result.man_count = 6'((i_dlen + 7'd1) >> 1);
        o_result.pwm_count = 5'(w_pwm_prod >> 9);
        w_pair  = '0;
        w_trip  = '0;
        w_whole = 1'b0;

        for (int k = 0; k < MAN_N; k++) begin
            w_pair  = {w_ext[PAY_W+1-2*k], w_ext[PAY_W-2*k]};
            w_whole = (7'(2*k+1) < i_dlen);
            o_result.man_data[k] = w_whole && (w_pair == MAN_ONE);
            o_result.man_bad[k]  = (7'(2*k) < i_dlen)
                && !(w_whole && ((w_pair == MAN_ONE) || (w_pair == MAN_ZERO)));
        end

        for (int k = 0; k < PWM_N; k++) begin
            w_trip  = {w_ext[PAY_W+1-3*k], w_ext[PAY_W-3*k], w_ext[PAY_W-1-3*k]};
            w_whole = (8'(3*k+2) < 8'(i_dlen));
            if (k < PWM_DATA_N) begin
                o_result.pwm_data[k] = w_whole && (w_trip == PWM_ONE);
            end
            o_result.pwm_bad[k] = (7'(3*k) < i_dlen)
                && !(w_whole && ((w_trip == PWM_ONE) || (w_trip == PWM_ZERO)));
        end
    end

endmodule

// ----- design/sync_word_payload_capture_top.sv -----
// Top level of the sync word correlator with payload capture.
//
//  channel   dir  handshake              payload
//  --------  ---  ---------------------  -------------------------------------------
//  s stream  in   i_s_tvalid/o_s_tready  i_s_tdata[0] bit_in, [7:1] zero
//  m stream  out  o_m_tvalid/i_m_tready  o_m_tdata: payload, man_*, pwm_* (see port)
//  cfg       in   i_cfg_we               i_cfg_index, i_cfg_data
//
// One bit word is taken every clock while o_s_tready is high. Each bit moves one cell
// along a row of bit cells that hold the history and capture chains, and the match of
// the history against the sync word is ready before the next bit arrives. A finished
// capture is decoded on the way into the output register and shows in the cycle after
// its last bit. Reset (synchronous, active low) clears both chains, both counters, the
// output valid flag and the configuration to sync word 0 and lengths 32. While a result
// waits, bits that cannot finish a capture are still accepted; only a bit that would
// finish the next capture holds until the output register frees up.
module sync_word_payload_capture_top #(
    parameter int MAX_SYNC_BITS = 64,
    parameter int MAX_DUMP_BITS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [swpc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [swpc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // [0] bit_in, [7:1] zero
    input  logic [swpc_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [63:0] payload, [95:64] man_data, [127:96] man_bad, [133:128] man_count,
    // [154:134] pwm_data, [176:155] pwm_bad, [181:177] pwm_count, [183:182] zero
    output logic [swpc_pkg::OUT_TDATA_W-1:0]    o_m_tdata
);
    import swpc_pkg::*;

    localparam int CHAIN_LEN = (MAX_SYNC_BITS > MAX_DUMP_BITS) ? MAX_SYNC_BITS
                                                               : MAX_DUMP_BITS;

    // configuration
    logic [CFG_DATA_W-1:0] r_sync_pattern;
    logic [LEN_W-1:0]      r_sync_len;
    logic [LEN_W-1:0]      r_pay_len;

    // counters and output register
    logic [LEN_W-1:0]      r_hist_count;
    logic [LEN_W-1:0]      n_hist_count;
    logic [LEN_W-1:0]      r_cap_count;
    logic [LEN_W-1:0]      n_cap_count;
    logic                  r_out_valid;
    logic                  n_out_valid;
    t_result               r_out;

    logic [LEN_W-1:0]      w_slen;
    logic [LEN_W-1:0]      w_dlen;
    logic [CHAIN_LEN-1:0]  w_hist;
    logic [CHAIN_LEN-1:0]  w_cap;
    logic [CHAIN_LEN-1:0]  w_hit;
    logic [CHAIN_LEN-1:0]  w_cap_next;
    logic [PAY_W-1:0]      w_payload;
    logic                  w_bit;
    logic                  w_match;
    logic [LEN_W-1:0]      w_cap_inc;
    logic                  w_complete;
    logic                  w_accept;
    t_cell_ctrl            w_ctrl;
    t_result               w_result;

    // clamp the lengths to 1..max
    always_comb begin
        if (r_sync_len == '0) begin
            w_slen = LEN_W'(1);
        end else if (r_sync_len > LEN_W'(MAX_SYNC_BITS)) begin
            w_slen = LEN_W'(MAX_SYNC_BITS);
        end else begin
            w_slen = r_sync_len;
        end
        if (r_pay_len == '0) begin
            w_dlen = LEN_W'(1);
        end else if (r_pay_len > LEN_W'(MAX_DUMP_BITS)) begin
            w_dlen = LEN_W'(MAX_DUMP_BITS);
        end else begin
            w_dlen = r_pay_len;
        end
    end

    assign w_bit = i_s_tdata[0];

    // the history stays frozen while capturing, so the match holds for the whole payload
    assign w_match    = (r_hist_count >= w_slen) && (&w_hit);
    assign w_cap_inc  = r_cap_count + LEN_W'(1);
    assign w_complete = w_match && (w_cap_inc >= w_dlen);

    // stall only a word that would finish a capture while the last result still waits
    assign o_s_tready = !r_out_valid || i_m_tready || !w_complete;
    assign w_accept   = i_s_tvalid && o_s_tready;

    assign w_ctrl.hist_shift = w_accept && !w_match;
    assign w_ctrl.cap_shift  = w_accept && w_match;

    // row of bit cells; bit 0 takes the new word, each cell hands its bit upward
    for (genvar gi = 0; gi < CHAIN_LEN; gi++) begin : g_cell
        if (gi == 0) begin : g_head
            assign w_cap_next[gi] = w_bit;
            swpc_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctrl    (w_ctrl),
                .i_hist_in (w_bit),
                .i_cap_in  (w_bit),
                .i_pat     (r_sync_pattern[gi]),
                .i_care    (LEN_W'(gi) < w_slen),
                .o_hist    (w_hist[gi]),
                .o_cap     (w_cap[gi]),
                .o_hit     (w_hit[gi])
            );
        end else begin : g_body
            assign w_cap_next[gi] = w_cap[gi-1];
            swpc_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctrl    (w_ctrl),
                .i_hist_in (w_hist[gi-1]),
                .i_cap_in  (w_cap[gi-1]),
                .i_pat     (r_sync_pattern[gi]),
                .i_care    (LEN_W'(gi) < w_slen),
                .o_hist    (w_hist[gi]),
                .o_cap     (w_cap[gi]),
                .o_hit     (w_hit[gi])
            );
        end
    end

    // keep only the newest payload-length bits; a shift by 64 leaves all ones
    assign w_payload = PAY_W'(w_cap_next) & ~({PAY_W{1'b1}} << w_dlen);

    swpc_decode u_decode (
        .i_payload (w_payload),
        .i_dlen    (w_dlen),
        .o_result  (w_result)
    );

    // counter and output valid next state
    always_comb begin
        n_hist_count = r_hist_count;
        n_cap_count  = r_cap_count;
        n_out_valid  = r_out_valid && !i_m_tready;
        if (w_accept) begin
            if (w_match) begin
                if (w_complete) begin
                    n_cap_count  = '0;
                    n_hist_count = '0;
                    n_out_valid  = 1'b1;
                end else begin
                    n_cap_count = w_cap_inc;
                end
            end else if (r_hist_count < w_slen) begin
                n_hist_count = r_hist_count + LEN_W'(1);
            end else begin
                n_hist_count = w_slen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_pattern <= '0;
            r_sync_len     <= LEN_W'(32);
            r_pay_len      <= LEN_W'(32);
            r_hist_count   <= '0;
            r_cap_count    <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SYNC_PATTERN: r_sync_pattern <= i_cfg_data;
                    CFG_SYNC_LEN:     r_sync_len     <= i_cfg_data[LEN_W-1:0];
                    CFG_PAY_LEN:      r_pay_len      <= i_cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            r_hist_count <= n_hist_count;
            r_cap_count  <= n_cap_count;
            r_out_valid  <= n_out_valid;
        end
    end

    // load the result word; hold it while the sink stalls
    always_ff @(posedge i_clk) begin
        if (w_accept && w_complete) begin
            r_out <= w_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the sync word correlator with payload capture block.
module testbench;
    import swpc_pkg::*;

    // Register index with no register behind it: writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    localparam int RANDOM_BITS   = 700;
    localparam int SETTLE_CYCLES = 4;     // a result shows in the cycle after its last bit
    localparam int STALL_LIMIT   = 2000;  // cycles with no word moving on any port

    typedef enum int {
        FILL_RANDOM,
        FILL_MANCHESTER,
        FILL_PWM
    } fill_kind_e;

    logic                   clk        = 1'b0;
    logic                   rst_n      = 1'b0;
    logic                   cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index  = '0;
    logic [CFG_DATA_W-1:0]  cfg_data   = '0;
    logic                   s_valid    = 1'b0;
    logic [IN_TDATA_W-1:0]  s_data     = '0;
    logic                   m_ready    = 1'b0;
    wire                    s_ready;
    wire                    m_valid;
    wire [OUT_TDATA_W-1:0]  m_data;

    // Mirror of the block's registers and state, kept in step with every accepted word
    logic [63:0] sync_word    = '0;
    logic [6:0]  sync_len_reg = 7'd32;
    logic [6:0]  pay_len_reg  = 7'd32;
    logic [63:0] hist_bits    = '0;
    int          hist_fill    = 0;
    logic [63:0] cap_bits     = '0;
    int          cap_fill     = 0;

    t_result expected_results[$];

    int err_count    = 0;
    int bits_sent    = 0;
    int stall_cycles = 0;
    bit steady_run   = 1'b0;   // suppress idling on both sides while set

    sync_word_payload_capture_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_valid),
        .o_s_tready  (s_ready),
        .i_s_tdata   (s_data),      // [0] bit_in, [7:1] ignored by the block
        .o_m_tvalid  (m_valid),
        .i_m_tready  (m_ready),
        .o_m_tdata   (m_data)       // t_result layout, payload in the lowest bits
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Lengths of zero act as one, anything past 64 saturates
    function automatic int eff_len(input logic [6:0] v);
        if (v == 7'd0) return 1;
        if (v > 7'd64) return 64;
        return int'(v);
    endfunction

    function automatic logic [63:0] low_mask(input int n);
        return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    endfunction

    // Split the payload into symbols in arrival order; first bit of a symbol is its MSB.
    // A symbol cut short by the end of the payload counts as bad, and a bad symbol
    // always decodes to a zero data bit.
    function automatic void decode_line_code(input logic [63:0] pay, input int len,
                                             input int width,
                                             input logic [2:0] one_code,
                                             input logic [2:0] zero_code,
                                             output logic [63:0] data,
                                             output logic [63:0] bad);
        int         count;
        int         idx;
        logic [2:0] sym;
        bit         whole;
        count = (len + width - 1) / width;
        data  = '0;
        bad   = '0;
        for (int k = 0; k < count; k++) begin
            sym   = '0;
            whole = 1'b1;
            for (int i = 0; i < width; i++) begin
                idx = k * width + i;
                sym = {sym[1:0], 1'b0};
                if (idx >= len)
                    whole = 1'b0;
                else
                    sym[0] = pay[len - 1 - idx];
            end
            if (whole && sym == one_code)
                data[k] = 1'b1;
            else if (!(whole && sym == zero_code))
                bad[k] = 1'b1;
        end
    endfunction

    // Take one bit into the correlator; queue the decoded frame when a capture fills up.
    // The match test uses the history as it stood before this bit.
    task automatic advance_correlator(input bit b);
        int          slen;
        int          dlen;
        logic [63:0] smask;
        logic [63:0] pay;
        logic [63:0] md, mb, pd, pb;
        t_result     frame;
        slen  = eff_len(sync_len_reg);
        dlen  = eff_len(pay_len_reg);
        smask = low_mask(slen);
        if (hist_fill >= slen && (hist_bits & smask) == (sync_word & smask)) begin
            cap_bits = {cap_bits[62:0], b};
            cap_fill++;
            if (cap_fill >= dlen) begin
                pay = cap_bits & low_mask(dlen);
                decode_line_code(pay, dlen, 2, {1'b0, MAN_ONE}, {1'b0, MAN_ZERO}, md, mb);
                decode_line_code(pay, dlen, 3, PWM_ONE, PWM_ZERO, pd, pb);
                frame           = '0;
                frame.payload   = pay;
                frame.man_data  = md[MAN_N-1:0];
                frame.man_bad   = mb[MAN_N-1:0];
                frame.man_count = 6'((dlen + 1) / 2);
                frame.pwm_data  = pd[PWM_DATA_N-1:0];
                frame.pwm_bad   = pb[PWM_N-1:0];
                frame.pwm_count = 5'((dlen + 2) / 3);
                expected_results.push_back(frame);
                // a fresh full sync word is needed before the next capture
                cap_fill  = 0;
                hist_fill = 0;
            end
        end else begin
            hist_bits = {hist_bits[62:0], b};
            if (hist_fill < slen)
                hist_fill++;
            else
                hist_fill = slen;
        end
    endtask

    // ------------------------------------------------------------------
    // Drivers (all drives at the rising edge, all sampling at the falling edge)
    // ------------------------------------------------------------------

    // Receiver back-pressure: drop ready with a chance of 38 in 100 unless in a steady stretch
    always @(posedge clk) begin
        m_ready <= steady_run ? 1'b1 : ($urandom_range(0, 99) >= 38);
    end

    // Send one bit word. Call at a rising edge; returns at the edge that takes the word.
    // Upper tdata bits carry junk the block must ignore.
    task automatic send_bit(input bit b);
        logic [IN_TDATA_W-1:0] word;
        bit                    accepted;
        word     = IN_TDATA_W'($urandom);
        word[0]  = b;
        accepted = 1'b0;
        while (!steady_run && $urandom_range(0, 99) < 38) begin
            s_valid <= 1'b0;
            @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= word;
        while (!accepted) begin
            @(negedge clk);
            accepted = s_ready;
            @(posedge clk);
        end
        bits_sent++;
        advance_correlator(b);
    endtask

    // Send the low n bits of a vector, MSB first
    task automatic send_bits(input logic [63:0] bits, input int n);
        for (int i = n - 1; i >= 0; i--)
            send_bit(bits[i]);
    endtask

    // Hold the sender until every queued frame has come out, then let the pipe settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write; the wait after it keeps one drive per signal per edge
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_SYNC_PATTERN: sync_word    = data;
            CFG_SYNC_LEN:     sync_len_reg = data[6:0];
            CFG_PAY_LEN:      pay_len_reg  = data[6:0];
            default:          ;
        endcase
    endtask

    // Write all three registers while the block is quiet; junk above the length bits
    // must be dropped by the block
    task automatic apply_config(input logic [63:0] pattern, input logic [6:0] slen,
                                input logic [6:0] dlen);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        wait_idle();
        cfg_write(CFG_SYNC_PATTERN, pattern);
        cfg_write(CFG_SYNC_LEN, {junk[63:7], slen});
        cfg_write(CFG_PAY_LEN, {junk[63:7] ^ 57'h1, dlen});
    endtask

    // Noise, the sync word, then a payload under the current lengths. A corrupted frame
    // flips one sync bit or cuts the payload short.
    task automatic send_frame(input bit corrupt);
        int         slen;
        int         dlen;
        int         flip;
        int         body_len;
        fill_kind_e kind;
        logic [2:0] sym;
        bit         payload_bits[$];
        slen     = eff_len(sync_len_reg);
        dlen     = eff_len(pay_len_reg);
        flip     = -1;
        body_len = dlen;
        if (corrupt) begin
            if ($urandom_range(0, 1))
                flip = $urandom_range(0, slen - 1);
            else
                body_len = $urandom_range(0, dlen - 1);
        end
        kind = fill_kind_e'($urandom_range(0, 2));
        while (payload_bits.size() < dlen) begin
            case (kind)
                FILL_RANDOM: begin
                    payload_bits.push_back(1'($urandom_range(0, 1)));
                end
                FILL_MANCHESTER: begin
                    if ($urandom_range(0, 9) == 0)
                        sym = 3'($urandom_range(0, 3));
                    else
                        sym = $urandom_range(0, 1) ? {1'b0, MAN_ONE} : {1'b0, MAN_ZERO};
                    payload_bits.push_back(sym[1]);
                    payload_bits.push_back(sym[0]);
                end
                default: begin
                    if ($urandom_range(0, 9) == 0)
                        sym = 3'($urandom_range(0, 7));
                    else
                        sym = $urandom_range(0, 1) ? PWM_ONE : PWM_ZERO;
                    payload_bits.push_back(sym[2]);
                    payload_bits.push_back(sym[1]);
                    payload_bits.push_back(sym[0]);
                end
            endcase
        end
        repeat ($urandom_range(0, 6)) send_bit(1'($urandom_range(0, 1)));
        for (int i = slen - 1; i >= 0; i--)
            send_bit(sync_word[i] ^ (i == flip));
        for (int i = 0; i < body_len; i++)
            send_bit(payload_bits[i]);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Registers untouched since reset: all-zero sync word, 32-bit sync and payload
    task automatic test_reset_config();
        repeat (2) send_frame(1'b0);
    endtask

    // Zero lengths act as one, so every bit after a single 1 lands in a one-bit capture
    // whose symbols are all incomplete. The write to the unmapped index must change nothing.
    task automatic test_short_lengths();
        apply_config(64'h1, 7'd0, 7'd0);
        cfg_write(CFG_UNMAPPED, '1);
        send_bits(64'b0101_1001, 8);
    endtask

    // Two-bit sync word with ignored high pattern bits, six-bit payloads covering every
    // Manchester pair and both PWM codes plus an unknown triple
    task automatic test_symbol_codes();
        apply_config(64'hFFFF_FFFF_FFFF_FFFE, 7'd2, 7'd6);
        send_bits(64'b10_100111_10_110100, 16);
    endtask

    // Shrink the payload length partway through a capture, then shrink the sync length
    // under a history already longer than it; both must act on the state already held
    task automatic test_change_mid_capture();
        apply_config(64'hB, 7'd4, 7'd8);
        send_bits(64'b1011_01, 6);
        wait_idle();
        cfg_write(CFG_PAY_LEN, 64'd2);
        send_bits(64'b1, 1);
        send_bits(64'b111, 3);
        wait_idle();
        cfg_write(CFG_SYNC_LEN, 64'd2);
        send_bits(64'b01, 2);
    endtask

    // Largest lengths, including values past the maximum that must saturate
    task automatic test_long_words();
        apply_config({$urandom, $urandom}, 7'd64, 7'd64);
        repeat (2) send_frame(1'b0);
        apply_config({$urandom, $urandom}, 7'd127, 7'd100);
        send_frame(1'b0);
    endtask

    // No idling on either side: one bit per clock through several captures
    task automatic test_back_to_back();
        steady_run = 1'b1;
        apply_config({$urandom, $urandom}, 7'd7, 7'd9);
        repeat (12) send_frame(1'b0);
        wait_idle();
        steady_run = 1'b0;
    endtask

    function automatic logic [6:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)  return 7'd0;
        if (r < 10) return 7'($urandom_range(65, 127));
        if (r < 15) return 7'($urandom_range(33, 64));
        return 7'($urandom_range(1, 12));
    endfunction

    // Mostly well-formed frames under random settings; trailing noise leaves partial
    // history or capture in place across each register change
    task automatic test_random_frames();
        int start;
        int frames;
        start = bits_sent;
        while (bits_sent - start < RANDOM_BITS) begin
            apply_config({$urandom, $urandom}, pick_len(), pick_len());
            if (eff_len(sync_len_reg) + eff_len(pay_len_reg) > 48)
                frames = 2;
            else
                frames = $urandom_range(4, 10);
            repeat (frames) send_frame($urandom_range(0, 99) < 15);
            repeat ($urandom_range(0, 8)) send_bit(1'($urandom_range(0, 1)));
        end
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            err_count++;
        end
    endfunction

    // Match each output word against the oldest queued frame
    always @(negedge clk) begin : check_result
        t_result got;
        t_result want;
        if (rst_n && m_valid && m_ready) begin
            got = m_data;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_data);
                err_count++;
            end else begin
                want = expected_results.pop_front();
                compare_field("payload",   want.payload,        got.payload);
                compare_field("man_data",  64'(want.man_data),  64'(got.man_data));
                compare_field("man_bad",   64'(want.man_bad),   64'(got.man_bad));
                compare_field("man_count", 64'(want.man_count), 64'(got.man_count));
                compare_field("pwm_data",  64'(want.pwm_data),  64'(got.pwm_data));
                compare_field("pwm_bad",   64'(want.pwm_bad),   64'(got.pwm_bad));
                compare_field("pwm_count", 64'(want.pwm_count), 64'(got.pwm_count));
                compare_field("spare",     64'(want.spare),     64'(got.spare));
            end
        end
    end

    // Abort when no word moves on any port for too long
    always @(negedge clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_config();
        test_short_lengths();
        test_symbol_codes();
        test_change_mid_capture();
        test_long_words();
        test_back_to_back();
        test_random_frames();
        wait_idle();
        if (err_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
